@@ rtl/olad_pkg.sv @@
`timescale 1ns / 1ps
package olad_pkg;

  // Field widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned ST_W  = 3;

  // Action codes carried on the input tuser
  localparam logic [ACT_W-1:0] ACT_APPEND  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DISPLAY = 2'd2;

  // Status codes carried on the output tuser
  localparam logic [ST_W-1:0] ST_APPENDED  = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_DELETED   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [ST_W-1:0] ST_ELEMENT   = 3'd0;

  // Source of a cell's next value
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_NEXT,
    SEL_HEAD
  } cell_sel_e;

  // Per-cell control from the sequencer
  typedef struct packed {
    cell_sel_e sel;
    logic      capture;
  } cell_ctl_t;

endpackage

@@ rtl/olad_cell.sv @@
`timescale 1ns / 1ps
module olad_cell (
  input  logic                      clk_i,
  input  olad_pkg::cell_ctl_t       ctl_i,
  input  logic [olad_pkg::VAL_W-1:0] key_i,
  input  logic [olad_pkg::VAL_W-1:0] load_i,
  input  logic [olad_pkg::VAL_W-1:0] next_i,
  input  logic [olad_pkg::VAL_W-1:0] head_i,
  output logic [olad_pkg::VAL_W-1:0] value_o,
  output logic                      match_o
);
  import olad_pkg::*;

  logic [VAL_W-1:0] value_q, value_d;
  logic             match_q, match_d;

  // Pick the next stored value: hold, new tail, neighbour or wrapped head
  always_comb begin
    unique case (ctl_i.sel)
      SEL_HOLD: value_d = value_q;
      SEL_LOAD: value_d = load_i;
      SEL_NEXT: value_d = next_i;
      SEL_HEAD: value_d = head_i;
      default:  value_d = value_q;
    endcase
  end

  // Compare against the key of a new request
  assign match_d = ctl_i.capture ? (value_q == key_i) : match_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    match_q <= match_d;
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

@@ rtl/ordered_list_append_delete_unit.sv @@
`timescale 1ns / 1ps
// Append, delete and a miss run as acceptance, where every cell compares its entry with
// the key, then an execute step that shifts the cells and registers the result; it waits while the output is full.
// Display emits one result per entry, or one empty status for an empty list, rotating the cell row once per result.
// The next request is accepted once the last result of a request sits in the output register.
// rst_ni is asynchronous and active low; it empties the list and clears the output valid.
module ordered_list_append_delete_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] element
  output logic [3:0]  m_axis_tuser,   // [2:0] status, [3] is_element
  output logic        m_axis_tlast
);
  import olad_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned LVL = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic             state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    ptr_q, ptr_d;

  logic             out_valid_q, out_valid_d;
  logic [ST_W-1:0]  out_status_q, out_status_d;
  logic             out_elem_q, out_elem_d;
  logic [VAL_W-1:0] out_data_q, out_data_d;
  logic             out_last_q, out_last_d;

  logic             accept;
  logic             out_free;
  logic             do_append, do_delete, do_rotate;
  logic [CW-1:0]    tail_idx;
  logic             found;

  logic [VAL_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0] match_raw;
  logic [DEPTH-1:0] hit;
  logic [DEPTH-1:0] pre [LVL+1];
  cell_ctl_t        cell_ctl [DEPTH];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign tail_idx      = count_q - CW'(1);

  // Prefix OR of the hits: a cell at or behind the first match closes the gap
  always_comb begin
    pre[0] = hit;
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (i >= (1 << l)) begin
          pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
        end else begin
          pre[l+1][i] = pre[l][i];
        end
      end
    end
  end

  assign found = pre[LVL][DEPTH-1];

  // Row of cells, each handing its value towards the head
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] nb;

    if (g < DEPTH - 1) begin : g_mid
      assign nb = cell_val[g+1];
    end else begin : g_end
      assign nb = cell_val[0];
    end

    assign hit[g] = match_raw[g] && (CW'(g) < count_q);

    always_comb begin
      cell_ctl[g].capture = accept;
      priority if (do_append && (CW'(g) == count_q)) begin
        cell_ctl[g].sel = SEL_LOAD;
      end else if (do_delete && pre[LVL][g]) begin
        cell_ctl[g].sel = SEL_NEXT;
      end else if (do_rotate && (CW'(g) == tail_idx)) begin
        cell_ctl[g].sel = SEL_HEAD;
      end else if (do_rotate) begin
        cell_ctl[g].sel = SEL_NEXT;
      end else begin
        cell_ctl[g].sel = SEL_HOLD;
      end
    end

    olad_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl[g]),
      .key_i   (s_axis_tdata),
      .load_i  (val_q),
      .next_i  (nb),
      .head_i  (cell_val[0]),
      .value_o (cell_val[g]),
      .match_o (match_raw[g])
    );
  end

  // Sequencer: latch the request, then execute it once the output register is free
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    val_d        = val_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    do_append    = 1'b0;
    do_delete    = 1'b0;
    do_rotate    = 1'b0;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_elem_d   = out_elem_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d   = s_axis_tuser;
          val_d   = s_axis_tdata;
          ptr_d   = '0;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (act_q != ACT_APPEND && act_q != ACT_DELETE && act_q != ACT_DISPLAY) begin
          // Drop an unused action without a result
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_elem_d   = 1'b0;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          out_status_d = ST_EMPTY;
          state_d      = S_IDLE;
          if (act_q == ACT_APPEND) begin
            if (count_q == CW'(DEPTH)) begin
              out_status_d = ST_FULL;
            end else begin
              out_status_d = ST_APPENDED;
              do_append    = 1'b1;
              count_d      = count_q + CW'(1);
            end
          end else if (act_q == ACT_DELETE) begin
            if (found) begin
              out_status_d = ST_DELETED;
              do_delete    = 1'b1;
              count_d      = count_q - CW'(1);
            end else begin
              out_status_d = ST_NOT_FOUND;
            end
          end else if (count_q != '0) begin
            // Emit the head and rotate it to the tail
            out_status_d = ST_ELEMENT;
            out_elem_d   = 1'b1;
            out_data_d   = cell_val[0];
            out_last_d   = (ptr_q == tail_idx);
            do_rotate    = 1'b1;
            ptr_d        = ptr_q + CW'(1);
            state_d      = (ptr_q == tail_idx) ? S_IDLE : S_EXEC;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_elem_q   <= out_elem_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = {out_elem_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count above depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> (count_q == $past(count_q) ||
                          count_q == $past(count_q) + CW'(1) ||
                          count_q == $past(count_q) - CW'(1)))
    else $error("list count moved by more than one");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && act_q == ACT_DISPLAY && count_q != '0) |-> ptr_q < count_q)
    else $error("display pointer beyond list");
`endif

endmodule

@@ verif/olad_list_checker.sv @@
`timescale 1ns / 1ps
// Watches both streams of the list unit, keeps its own copy of the list,
// and checks every result against the oldest one still awaited.
module olad_list_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [olad_pkg::VAL_W-1:0]  s_tdata_i,    // [31:0] value
  input  logic [olad_pkg::ACT_W-1:0]  s_tuser_i,    // [1:0] action
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [olad_pkg::VAL_W-1:0]  m_tdata_i,    // [31:0] element
  input  logic [olad_pkg::ST_W:0]     m_tuser_i,    // [2:0] status, [3] is_element
  input  logic                        m_tlast_i,
  output int                          pending_o,
  output int                          fail_count_o
);
  import olad_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             is_element;
    logic [VAL_W-1:0] element;
    logic             last;
  } list_result_t;

  // Shadow of the list contents, head at index 0
  logic [VAL_W-1:0] held_vals [DEPTH];
  int unsigned      held_n;
  list_result_t     awaited_q [$];

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                 input logic [VAL_W-1:0] want);
    fail_count_o++;
    $display("%0t ns list check: %s got %0h want %0h", $time, what, got, want);
  endtask

  // Update the shadow list for one request and queue the results it causes
  task automatic apply_request(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
    int unsigned  i;
    int unsigned  hit;
    list_result_t r;
    r      = '0;
    r.last = 1'b1;
    case (act)
      ACT_APPEND: begin
        if (held_n >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_vals[held_n] = val;
          held_n++;
          r.status = ST_APPENDED;
        end
        awaited_q.push_back(r);
      end
      ACT_DELETE: begin
        hit = held_n;
        for (i = 0; i < held_n; i++) begin
          if (hit == held_n && held_vals[i] == val) hit = i;
        end
        if (hit == held_n) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // close the gap behind the removed entry
          for (i = hit; i + 1 < held_n; i++) held_vals[i] = held_vals[i+1];
          held_n--;
          r.status = ST_DELETED;
        end
        awaited_q.push_back(r);
      end
      ACT_DISPLAY: begin
        if (held_n == 0) begin
          r.status = ST_EMPTY;
          awaited_q.push_back(r);
        end else begin
          for (i = 0; i < held_n; i++) begin
            r.status     = ST_ELEMENT;
            r.is_element = 1'b1;
            r.element    = held_vals[i];
            r.last       = (i + 1 == held_n);
            awaited_q.push_back(r);
          end
        end
      end
      default: ;  // unused action: nothing changes, nothing comes out
    endcase
  endtask

  initial held_n = 0;

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk_i) begin : watch
    list_result_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) apply_request(s_tuser_i, s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with none awaited, data", m_tdata_i, '0);
        end else begin
          want = awaited_q.pop_front();
          if (m_tuser_i[ST_W-1:0] !== want.status)
            report_mismatch("status", VAL_W'(m_tuser_i[ST_W-1:0]), VAL_W'(want.status));
          if (m_tuser_i[ST_W] !== want.is_element)
            report_mismatch("is_element", VAL_W'(m_tuser_i[ST_W]), VAL_W'(want.is_element));
          if (m_tdata_i !== want.element)
            report_mismatch("element", m_tdata_i, want.element);
          if (m_tlast_i !== want.last)
            report_mismatch("last", VAL_W'(m_tlast_i), VAL_W'(want.last));
        end
      end
    end
    pending_o <= awaited_q.size();
  end

endmodule

@@ verif/tb_ordered_list_append_delete_unit.sv @@
`timescale 1ns / 1ps
module tb_ordered_list_append_delete_unit;
  import olad_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_REQS = 230;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] VAL_ONES = 32'hffff_ffff;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_e;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [VAL_W-1:0] s_axis_tdata;
  logic [ACT_W-1:0] s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [VAL_W-1:0] m_axis_tdata;
  logic [ST_W:0]    m_axis_tuser;
  logic             m_axis_tlast;

  logic             steady = 1'b0;
  int               pending;
  int               fails;
  int               sent;
  logic [VAL_W-1:0] appended_q [$];

  ordered_list_append_delete_unit #(.DEPTH(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  olad_list_checker #(.DEPTH(DEPTH)) list_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .pending_o   (pending),
    .fail_count_o(fails)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one, none while steady
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  // Bias values towards extremes and a few small ones so keys repeat
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return VAL_ONES;
      4, 5:    return $urandom_range(1, 6);
      default: return $urandom;
    endcase
  endfunction

  // Prefer keys that were appended recently so deletes mostly hit
  function automatic logic [VAL_W-1:0] pick_key();
    if (appended_q.size() != 0 && $urandom_range(0, 9) < 7)
      return appended_q[$urandom_range(0, appended_q.size() - 1)];
    return pick_value();
  endfunction

  // Present one request, hold until accepted, then maybe idle
  task automatic send_req(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (act == ACT_APPEND) begin
      appended_q.push_back(val);
      if (appended_q.size() > 32) void'(appended_q.pop_front());
    end
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every awaited result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Result sink: random stalls of mixed length
  initial begin : sink
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!steady) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3: hold = $urandom_range(1, 3);
            4:          hold = $urandom_range(10, 30);
            default:    ;
          endcase
        end
      end
    end
  end

  initial begin : stim
    burst_e mode;
    int     burst;
    int     n;
    int     k;
    int     r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_APPEND;
    sent          = 0;
    burst         = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list, single entry, extremes, duplicates, misses
    send_req(ACT_DISPLAY, '0);
    send_req(ACT_DELETE, '0);
    send_req(ACT_UNUSED, VAL_ONES);
    send_req(ACT_APPEND, VAL_MAX);
    send_req(ACT_DISPLAY, VAL_ONES);
    send_req(ACT_DELETE, VAL_MAX);
    send_req(ACT_DISPLAY, '0);
    send_req(ACT_APPEND, VAL_MIN);
    send_req(ACT_APPEND, '0);
    send_req(ACT_APPEND, VAL_ONES);
    send_req(ACT_APPEND, VAL_MIN);
    send_req(ACT_DELETE, 32'd12345);
    send_req(ACT_DELETE, '0);
    send_req(ACT_DELETE, VAL_MIN);
    send_req(ACT_DISPLAY, '0);
    send_req(ACT_DELETE, VAL_MIN);
    send_req(ACT_DELETE, VAL_ONES);
    send_req(ACT_UNUSED, '0);
    wait_drained();

    // Random bursts: fill past full first, then drain, then mix
    while (sent < RANDOM_REQS) begin
      if (burst == 0) mode = BURST_FILL;
      else if (burst == 1) mode = BURST_DRAIN;
      else mode = burst_e'($urandom_range(0, 2));
      steady = ($urandom_range(0, 3) == 0);
      n = (burst < 2) ? 20 : $urandom_range(8, 20);
      for (k = 0; k < n; k++) begin
        case (mode)
          BURST_FILL: begin
            if (k == n - 1 || (burst != 0 && $urandom_range(0, 7) == 0))
              send_req(ACT_DISPLAY, $urandom);
            else
              send_req(ACT_APPEND, pick_value());
          end
          BURST_DRAIN: begin
            if (k == n - 1) send_req(ACT_DISPLAY, $urandom);
            else send_req(ACT_DELETE, pick_key());
          end
          default: begin
            r = $urandom_range(0, 19);
            if (r < 8) send_req(ACT_APPEND, pick_value());
            else if (r < 15) send_req(ACT_DELETE, pick_key());
            else if (r < 19) send_req(ACT_DISPLAY, $urandom);
            else send_req(ACT_UNUSED, $urandom);
          end
        endcase
      end
      if (burst == 0 || $urandom_range(0, 3) == 0) wait_drained();
      burst++;
    end

    // Let everything out, then watch a while for strays
    s_axis_tvalid <= 1'b0;
    steady = 1'b1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3 * DEPTH) @(posedge clk_i);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/olad_pkg.sv
rtl/olad_cell.sv
rtl/ordered_list_append_delete_unit.sv
verif/olad_list_checker.sv
verif/tb_ordered_list_append_delete_unit.sv
